### sv/anbs_pkg.sv
package anbs_pkg;

  localparam int BYTE_W = 8;
  localparam int TYPE_W = 5;
  localparam int PRI_W = 2;
  localparam int IDX_W = 23;
  localparam int MASK_W = 32;

  // most results one input byte can cause: four committed bytes plus a closing one
  localparam int MAX_RES = 5;
  localparam int CNT_W = 3;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam int MAX_NAL_BYTES_DEF = 8388608;
  localparam logic [MASK_W-1:0] PASS_MASK_RST = 32'h0000_01BF;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONE = 8'h01;

  typedef struct packed {
    logic [BYTE_W-1:0] nal_byte;
    logic [TYPE_W-1:0] nal_type;
    logic [PRI_W-1:0]  ref_priority;
    logic              forbidden;
    logic              first_of_nal;
    logic              last_of_nal;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_error;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] slot;
    logic [CNT_W-1:0]   count;
  } burst_t;

  // base + step, clipped at limit
  function automatic logic [IDX_W-1:0] sat_idx(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] step,
                                               input logic [IDX_W-1:0] limit);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {{(IDX_W+1-CNT_W){1'b0}}, step};
    if (sum > {1'b0, limit}) begin
      return limit;
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### sv/anbs_ifs.sv
interface anbs_in_if;
  import anbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_of_frame;
  modport source(output valid, output data_byte, output last_of_frame, input ready);
  modport sink(input valid, input data_byte, input last_of_frame, output ready);
endinterface

interface anbs_out_if;
  import anbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] nal_byte;
  logic [TYPE_W-1:0] nal_type;
  logic [PRI_W-1:0]  ref_priority;
  logic              forbidden;
  logic              first_of_nal;
  logic              last_of_nal;
  logic [IDX_W-1:0]  byte_index;
  logic              frame_error;
  modport source(output valid, output nal_byte, output nal_type, output ref_priority,
                 output forbidden, output first_of_nal, output last_of_nal,
                 output byte_index, output frame_error, input ready);
  modport sink(input valid, input nal_byte, input nal_type, input ref_priority,
               input forbidden, input first_of_nal, input last_of_nal,
               input byte_index, input frame_error, output ready);
endinterface

### sv/anbs_parser.sv
module anbs_parser #(
  parameter int MAX_NAL_BYTES = anbs_pkg::MAX_NAL_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic [anbs_pkg::BYTE_W-1:0]  a_byte,
  input  logic                         a_last,
  input  logic [anbs_pkg::MASK_W-1:0]  pass_mask,
  output anbs_pkg::burst_t             burst
);
  import anbs_pkg::*;

  localparam logic [IDX_W-1:0] IdxLimit =
    ((MAX_NAL_BYTES - 1) > int'(IDX_MAX)) ? IDX_MAX : IDX_W'(MAX_NAL_BYTES - 1);

  typedef enum logic [1:0] {PH_EXPECT, PH_UNIT, PH_DROP} phase_t;

  phase_t            phase, phase_next;
  logic [1:0]        zero_run, zero_run_next;
  logic [2:0]        prefix_count, prefix_count_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  logic [BYTE_W-1:0] unit_header, unit_header_next;
  logic              unit_pass, unit_pass_next;
  logic [IDX_W-1:0]  unit_index, unit_index_next;

  logic              is_zero, is_one, start_code, fin, tail, err;
  logic [CNT_W-1:0]  nz, n, len, m;
  logic [BYTE_W-1:0] hdr_eff;
  logic              pass_eff;
  logic [IDX_W-1:0]  idx_k;

  always_comb begin
    phase_next        = phase;
    zero_run_next     = zero_run;
    prefix_count_next = prefix_count;
    held_byte_next    = held_byte;
    held_valid_next   = held_valid;
    unit_header_next  = unit_header;
    unit_pass_next    = unit_pass;
    unit_index_next   = unit_index;
    burst             = '0;
    err               = 1'b0;
    is_zero    = (a_byte == BYTE_ZERO);
    is_one     = (a_byte == BYTE_ONE);
    start_code = is_one && (zero_run >= 2'd2);
    nz         = '0;
    tail       = 1'b0;
    fin        = 1'b0;
    n          = '0;
    len        = '0;
    m          = '0;
    hdr_eff    = unit_header;
    pass_eff   = unit_pass;
    idx_k      = '0;

    case (phase)
      PH_EXPECT: begin
        if (is_zero && (prefix_count < 3'd3)) begin
          prefix_count_next = prefix_count + 3'd1;
          err = a_last;
        end else if (is_one && (prefix_count >= 3'd2)) begin
          prefix_count_next = '0;
          zero_run_next     = '0;
          held_byte_next    = '0;
          held_valid_next   = 1'b0;
          unit_header_next  = '0;
          unit_pass_next    = 1'b0;
          unit_index_next   = '0;
          phase_next        = a_last ? PH_EXPECT : PH_UNIT;
        end else begin
          err = 1'b1;
        end
        if (err) begin
          burst.slot[0].frame_error = 1'b1;
          burst.count               = CNT_W'(1);
          prefix_count_next         = '0;
          phase_next                = a_last ? PH_EXPECT : PH_DROP;
        end
      end

      PH_UNIT: begin
        // committed bytes this step: nz zeros, then the input byte if tail
        if (is_zero) begin
          if (a_last) begin
            nz = {1'b0, zero_run} + CNT_W'(1);
          end else begin
            nz = (zero_run == 2'd3) ? CNT_W'(1) : CNT_W'(0);
            zero_run_next = (zero_run == 2'd3) ? zero_run : zero_run + 2'd1;
          end
        end else if (!start_code) begin
          nz            = {1'b0, zero_run};
          tail          = 1'b1;
          zero_run_next = '0;
        end else begin
          zero_run_next = '0;
        end
        fin = start_code || a_last;
        n   = nz + {{(CNT_W-1){1'b0}}, tail};
        len = n + {{(CNT_W-1){1'b0}}, held_valid};
        m   = (len == '0) ? '0 : len - CNT_W'(1) + {{(CNT_W-1){1'b0}}, fin};

        if (!held_valid) begin
          hdr_eff  = (tail && (nz == '0)) ? a_byte : BYTE_ZERO;
          pass_eff = pass_mask[hdr_eff[TYPE_W-1:0]];
        end

        for (int k = 0; k < MAX_RES; k++) begin
          idx_k = sat_idx(unit_index, CNT_W'(k), IdxLimit);
          if (held_valid && (k == 0)) begin
            burst.slot[k].nal_byte = held_byte;
          end else if (tail && (len == CNT_W'(k + 1))) begin
            burst.slot[k].nal_byte = a_byte;
          end else begin
            burst.slot[k].nal_byte = BYTE_ZERO;
          end
          burst.slot[k].nal_type     = hdr_eff[TYPE_W-1:0];
          burst.slot[k].ref_priority = hdr_eff[6:5];
          burst.slot[k].forbidden    = hdr_eff[7];
          burst.slot[k].byte_index   = idx_k;
          burst.slot[k].first_of_nal = (idx_k == '0);
          burst.slot[k].last_of_nal  = fin && (len == CNT_W'(k + 1));
          burst.slot[k].frame_error  = 1'b0;
        end
        burst.count = pass_eff ? m : '0;

        if (fin) begin
          zero_run_next    = '0;
          held_byte_next   = '0;
          held_valid_next  = 1'b0;
          unit_header_next = '0;
          unit_pass_next   = 1'b0;
          unit_index_next  = '0;
          if (a_last) begin
            phase_next        = PH_EXPECT;
            prefix_count_next = '0;
          end
        end else begin
          unit_index_next = sat_idx(unit_index, m, IdxLimit);
          if (len != '0) begin
            held_valid_next  = 1'b1;
            held_byte_next   = tail ? a_byte : ((n == '0) ? held_byte : BYTE_ZERO);
            unit_header_next = hdr_eff;
            unit_pass_next   = pass_eff;
          end
        end
      end

      PH_DROP: begin
        if (a_last) begin
          phase_next        = PH_EXPECT;
          prefix_count_next = '0;
        end
      end

      default: begin
        phase_next = PH_EXPECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_EXPECT;
      zero_run     <= '0;
      prefix_count <= '0;
      held_byte    <= '0;
      held_valid   <= 1'b0;
      unit_header  <= '0;
      unit_pass    <= 1'b0;
      unit_index   <= '0;
    end else if (adv) begin
      phase        <= phase_next;
      zero_run     <= zero_run_next;
      prefix_count <= prefix_count_next;
      held_byte    <= held_byte_next;
      held_valid   <= held_valid_next;
      unit_header  <= unit_header_next;
      unit_pass    <= unit_pass_next;
      unit_index   <= unit_index_next;
    end
  end

endmodule

### sv/anbs_serial.sv
module anbs_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  anbs_pkg::burst_t burst,
  output logic             free,
  anbs_out_if.source       out_ch
);
  import anbs_pkg::*;

  anbs_pkg::burst_t hold;
  logic             valid;
  logic [CNT_W-1:0] ptr;
  logic             last_slot;
  logic             fire;
  logic             load;

  assign last_slot = (ptr == hold.count - CNT_W'(1));
  assign fire      = valid && out_ch.ready;
  assign free      = !valid || (out_ch.ready && last_slot);
  assign load      = take && (burst.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      ptr   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      ptr   <= '0;
    end else if (fire) begin
      if (last_slot) begin
        valid <= 1'b0;
        ptr   <= '0;
      end else begin
        ptr <= ptr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= burst;
    end
  end

  assign out_ch.valid        = valid;
  assign out_ch.nal_byte     = hold.slot[ptr].nal_byte;
  assign out_ch.nal_type     = hold.slot[ptr].nal_type;
  assign out_ch.ref_priority = hold.slot[ptr].ref_priority;
  assign out_ch.forbidden    = hold.slot[ptr].forbidden;
  assign out_ch.first_of_nal = hold.slot[ptr].first_of_nal;
  assign out_ch.last_of_nal  = hold.slot[ptr].last_of_nal;
  assign out_ch.byte_index   = hold.slot[ptr].byte_index;
  assign out_ch.frame_error  = hold.slot[ptr].frame_error;

`ifndef SYNTHESIS
  a_ptr_in_burst: assert property (@(posedge clk) disable iff (rst)
    valid |-> (ptr < hold.count))
    else $error("slot pointer beyond burst");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (valid && !out_ch.ready) |=> (valid && $stable(ptr)))
    else $error("burst moved while stalled");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && last_slot && !load) |=> !valid)
    else $error("burst did not end after its last slot");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("output valid after reset");
`endif

endmodule

### sv/annexb_nal_unit_splitter.sv
// Channel   Modport        Transaction
// --------  -------------  -------------------------------------------------
// in_ch     anbs_in_if     one frame byte, last_of_frame on the final byte
// out_ch    anbs_out_if    one unit byte with header tags, or a frame error
// cfg_*     write only     pass_mask, taken when cfg_we is high
//
// Each input byte is registered and then parsed; its 0 to 5 results load as a burst
// into the output stage, which hands them out one per cycle while out_ch is ready. A
// byte with several results holds the input side until its burst is handed out.
// Path: input register, combinational parser, burst register of the output stage.
// rst is synchronous: clears parser state, empties both stages, mask back to 0x1BF.
// A stalled output keeps its burst; one more input byte waits in the input register.
module annexb_nal_unit_splitter #(
  parameter int MAX_NAL_BYTES = anbs_pkg::MAX_NAL_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  anbs_in_if.sink                     in_ch,
  anbs_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [anbs_pkg::MASK_W-1:0] cfg_wdata
);
  import anbs_pkg::*;

  logic [MASK_W-1:0] pass_mask;

  // input register
  logic              a_valid;
  logic [BYTE_W-1:0] a_byte;
  logic              a_last;

  logic   free;
  logic   adv;
  burst_t burst;

  // parse the registered byte when the output stage can take its burst
  assign adv         = a_valid && free;
  assign in_ch.ready = !a_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_mask <= PASS_MASK_RST;
    end else if (cfg_we) begin
      pass_mask <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte <= in_ch.data_byte;
      a_last <= in_ch.last_of_frame;
    end
  end

  anbs_parser #(
    .MAX_NAL_BYTES(MAX_NAL_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .a_byte   (a_byte),
    .a_last   (a_last),
    .pass_mask(pass_mask),
    .burst    (burst)
  );

  anbs_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .take  (adv),
    .burst (burst),
    .free  (free),
    .out_ch(out_ch)
  );

endmodule

### test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import anbs_pkg::*;

  // Unit limit handed to the block; the predictor caps byte_index to match.
  localparam int UNIT_BYTES_MAX = 1024;
  localparam logic [IDX_W-1:0] INDEX_CAP =
    (UNIT_BYTES_MAX - 1 > int'(IDX_MAX)) ? IDX_MAX : IDX_W'(UNIT_BYTES_MAX - 1);

  localparam int ITEMS_PER_PHASE = 30;
  // Idle wait once nothing is queued or owed. Used before mask writes
  // and at the end, so that a byte with no results has cleared the pipeline.
  localparam int SETTLE_CYCLES = 10;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {SEEK_START, IN_UNIT, SKIP_FRAME} parse_phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eof;
  } frame_byte_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  anbs_in_if  in_ch();
  anbs_out_if out_ch();

  annexb_nal_unit_splitter #(
    .MAX_NAL_BYTES(UNIT_BYTES_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bytes waiting to be offered, and unit bytes / errors the block owes us.
  frame_byte_t frame_bytes_q[$];
  res_t        nal_due[$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int bytes_in;
  int unit_bytes_seen;
  int errors_seen;
  int stall_cycles;

  // ---------------------------------------------------------------------------
  // Splitter shadow: parser state and the mask as the block should hold them
  // ---------------------------------------------------------------------------
  parse_phase_e      parse_phase;
  logic [2:0]        lead_zeros;   // zeros of the opening start code so far
  logic [1:0]        zeros_held;   // tentative zeros inside a unit
  logic [BYTE_W-1:0] held_byte;    // newest committed byte, not yet known to be last
  logic              unit_open;
  logic [BYTE_W-1:0] unit_hdr;
  logic              unit_passes;
  logic [IDX_W-1:0]  next_index;
  logic [MASK_W-1:0] type_mask;

  task automatic clear_unit();
    zeros_held  = '0;
    held_byte   = '0;
    unit_open   = 1'b0;
    unit_hdr    = '0;
    unit_passes = 1'b0;
    next_index  = '0;
  endtask

  // Emit one unit byte if the unit passes the mask; the index moves on up to INDEX_CAP regardless.
  task automatic emit_unit_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    res_t r;
    if (unit_passes) begin
      r              = '0;
      r.nal_byte     = b;
      r.nal_type     = unit_hdr[4:0];
      r.ref_priority = unit_hdr[6:5];
      r.forbidden    = unit_hdr[7];
      r.first_of_nal = (next_index == '0);
      r.last_of_nal  = is_last;
      r.byte_index   = next_index;
      nal_due.push_back(r);
    end
    if (next_index < INDEX_CAP) next_index++;
  endtask

  // Add a byte to the unit; the byte held until now goes out as a non-last byte.
  // The pass decision is latched here, on the header byte, and never revisited.
  task automatic commit_unit_byte(input logic [BYTE_W-1:0] b);
    if (!unit_open) begin
      unit_hdr    = b;
      unit_passes = type_mask[b[4:0]];
      unit_open   = 1'b1;
    end else begin
      emit_unit_byte(held_byte, 1'b0);
    end
    held_byte = b;
  endtask

  task automatic close_unit();
    if (unit_open) emit_unit_byte(held_byte, 1'b1);
    clear_unit();
  endtask

  task automatic flush_held_zeros();
    while (zeros_held > 0) begin
      commit_unit_byte(BYTE_ZERO);
      zeros_held--;
    end
  endtask

  // One accepted input byte: works out everything it should make the block produce.
  task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic eof);
    res_t r;
    case (parse_phase)
      SEEK_START: begin
        if (b == BYTE_ZERO && lead_zeros < 3'd3 && !eof) begin
          lead_zeros++;
        end else if (b == BYTE_ONE && lead_zeros >= 3'd2) begin
          lead_zeros  = '0;
          clear_unit();
          parse_phase = eof ? SEEK_START : IN_UNIT;
        end else begin
          // no opening start code (bad byte, a fourth zero, or the frame ran out)
          r             = '0;
          r.frame_error = 1'b1;
          nal_due.push_back(r);
          lead_zeros    = '0;
          parse_phase   = eof ? SEEK_START : SKIP_FRAME;
        end
      end
      SKIP_FRAME: begin
        if (eof) begin
          parse_phase = SEEK_START;
          lead_zeros  = '0;
        end
      end
      default: begin
        if (b == BYTE_ZERO) begin
          if (zeros_held < 2'd3) zeros_held++;
          else commit_unit_byte(BYTE_ZERO);
        end else if (b == BYTE_ONE && zeros_held >= 2'd2) begin
          // start code: the held zeros were its own, the unit ends here
          close_unit();
        end else begin
          flush_held_zeros();
          commit_unit_byte(b);
        end
        if (eof) begin
          // zeros still held at the frame's end belong to the unit
          flush_held_zeros();
          close_unit();
          parse_phase = SEEK_START;
          lead_zeros  = '0;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, holds a byte until its transaction completes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_byte_t nb;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.data_byte, in_ch.last_of_frame);
        bytes_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (frame_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nb = frame_bytes_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= nb.data;
          in_ch.last_of_frame <= nb.eof;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, every output transaction checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (nal_due.size() == 0) begin
          $error("unexpected result: nal_byte 0x%0h, frame_error %0b",
                 out_ch.nal_byte, out_ch.frame_error);
          fail_count++;
        end else begin
          want = nal_due.pop_front();
          check_field("nal_byte", 32'(want.nal_byte), 32'(out_ch.nal_byte));
          check_field("nal_type", 32'(want.nal_type), 32'(out_ch.nal_type));
          check_field("ref_priority", 32'(want.ref_priority), 32'(out_ch.ref_priority));
          check_field("forbidden", 32'(want.forbidden), 32'(out_ch.forbidden));
          check_field("first_of_nal", 32'(want.first_of_nal), 32'(out_ch.first_of_nal));
          check_field("last_of_nal", 32'(want.last_of_nal), 32'(out_ch.last_of_nal));
          check_field("byte_index", 32'(want.byte_index), 32'(out_ch.byte_index));
          check_field("frame_error", 32'(want.frame_error), 32'(out_ch.frame_error));
          if (want.frame_error) errors_seen++;
          else unit_bytes_seen++;
        end
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               stall_cycles, nal_due.size());
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue a byte sequence; closed puts last_of_frame on its final byte.
  function automatic int queue_frame(input logic [BYTE_W-1:0] fb[$], input logic closed);
    for (int i = 0; i < fb.size(); i++) begin
      frame_bytes_q.push_back('{fb[i], closed && (i == fb.size() - 1)});
    end
    return fb.size();
  endfunction

  // Payload leans on 00 and 01 so that zero runs and near start codes are common.
  function automatic logic [BYTE_W-1:0] payload_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return BYTE_ZERO;
    if (pick == 4) return BYTE_ONE;
    if (pick == 5) return 8'h03;
    return BYTE_W'($urandom);
  endfunction

  function automatic int queue_random_frame();
    logic [BYTE_W-1:0] fb[$];
    int n_units;
    if ($urandom_range(0, 99) < 75) begin
      // well formed: three or four byte opening start code, then one to three units
      fb = {BYTE_ZERO, BYTE_ZERO};
      if ($urandom_range(0, 1) != 0) fb.push_back(BYTE_ZERO);
      fb.push_back(BYTE_ONE);
      n_units = $urandom_range(1, 3);
      for (int u = 0; u < n_units; u++) begin
        if (u > 0) begin
          repeat ($urandom_range(2, 5)) fb.push_back(BYTE_ZERO);
          fb.push_back(BYTE_ONE);
        end
        if ($urandom_range(0, 9) != 0) begin
          fb.push_back(BYTE_W'($urandom));
          repeat ($urandom_range(0, 8)) fb.push_back(payload_byte());
        end
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) fb.push_back(BYTE_ZERO);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          // no start code at all
          fb.push_back(BYTE_W'($urandom_range(2, 255)));
          repeat ($urandom_range(0, 3)) fb.push_back(BYTE_W'($urandom));
        end
        1: begin
          // too many leading zeros
          repeat ($urandom_range(4, 5)) fb.push_back(BYTE_ZERO);
          fb.push_back(BYTE_ONE);
          repeat ($urandom_range(0, 2)) fb.push_back(BYTE_W'($urandom));
        end
        2: begin
          // frame stops part way into the opening start code
          repeat ($urandom_range(1, 3)) fb.push_back(BYTE_ZERO);
        end
        default: begin
          // a single zero before the 01
          fb = {BYTE_ZERO, BYTE_ONE};
          repeat ($urandom_range(0, 3)) fb.push_back(payload_byte());
        end
      endcase
    end
    return queue_frame(fb, 1'b1);
  endfunction

  task automatic queue_random_phase(input int n_items);
    int queued;
    queued = 0;
    while (queued < n_items) queued += queue_random_frame();
  endtask

  // Block idle: nothing queued or offered, nothing owed, pipeline given time to empty.
  task automatic wait_idle();
    do @(negedge clk);
    while (frame_bytes_q.size() != 0 || in_ch.valid || nal_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    type_mask  = m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [BYTE_W-1:0] fb[$];

    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.last_of_frame = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    fail_count          = 0;
    bytes_in            = 0;
    unit_bytes_seen     = 0;
    errors_seen         = 0;
    stall_cycles        = 0;
    send_idle_pct       = 35;
    recv_idle_pct       = 80;

    parse_phase = SEEK_START;
    lead_zeros  = '0;
    type_mask   = PASS_MASK_RST;
    clear_unit();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frame under the reset mask: four zeros inside a unit, an empty unit,
    // a unit of a blocked type, and zeros held at the frame's end.
    fb = {8'h00, 8'h00, 8'h01, 8'hE5, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
          8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h06,
          8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00};
    void'(queue_frame(fb, 1'b1));
    // Four leading zeros with the error on the frame's last byte.
    fb = {8'h00, 8'h00, 8'h00, 8'h00};
    void'(queue_frame(fb, 1'b1));
    // Frame that ends inside its opening start code.
    fb = {8'h00, 8'h00};
    void'(queue_frame(fb, 1'b1));
    // One byte frame that is not a start code.
    fb = {8'hFF};
    void'(queue_frame(fb, 1'b1));
    wait_idle();

    // Random phases over several masks; idling shifts from sender-light to
    // receiver-light to none.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_mask(32'hFFFF_FFFF);
        1: write_mask(MASK_W'($urandom));
        2: write_mask('0);
        3: write_mask(MASK_W'($urandom));
        4: write_mask(PASS_MASK_RST);
        default: write_mask(MASK_W'($urandom) | 32'h0000_0002);
      endcase
      send_idle_pct = (p < 2) ? 35 : (p < 4) ? 80 : 0;
      recv_idle_pct = (p < 2) ? 80 : (p < 4) ? 35 : 0;
      queue_random_phase(ITEMS_PER_PHASE);
      if (p == 3) begin
        // leave a type 6 unit open across the next mask write
        fb = {BYTE_ZERO, BYTE_ZERO, BYTE_ONE, {1'b0, 2'($urandom), 5'd6}, 8'hAB};
        void'(queue_frame(fb, 1'b0));
      end
      wait_idle();
    end

    if (nal_due.size() != 0) begin
      $error("%0d expected results never arrived", nal_due.size());
      fail_count++;
    end
    $display("summary: %0d frame bytes sent, %0d unit bytes and %0d frame errors checked",
             bytes_in, unit_bytes_seen, errors_seen);
    $display("summary: masks reset, all ones, zero and random; index capped at %0d",
             INDEX_CAP);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
